>>> design/ted_pkg.sv
// Shared constants for the token edit distance core.
`timescale 1ns / 1ps

package ted_pkg;

  // Field widths of the stream words
  localparam int TOKEN_BITS = 32;
  localparam int CMD_BITS   = 2;
  localparam int DIST_BITS  = 16;

  // Command codes carried on the input tuser
  localparam logic [CMD_BITS-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_STEP   = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_FINISH = 2'd2;

  // Largest distance that fits the output field
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

endpackage

>>> design/token_edit_distance_core.sv
// Top level of the token edit distance core: command decode, row sequencer and result register.
`timescale 1ns / 1ps

// Levenshtein distance between two token sequences, unit costs.
// Input stream: s_tuser carries the command (load, step, finish), s_tdata the token.
// Load words fill the first sequence, one token per word, until the first step;
// a load once the store is full is dropped and raises the error flag.
// Each step word carries one token of the second sequence and sweeps the cost
// row held in block RAM, one cell per cycle: read, update, write back. While a
// step sweeps its N cells, N being the number of loaded tokens (256 with a full
// default store), the core takes no further word until the sweep has ended.
// Load words and unused commands are taken without holding up the input.
// A finish word places the distance on m_tdata and the error flag on m_tuser
// in the cycle after it is taken and returns the core to its empty state.
// The result sits in an output register: further words are taken while it waits,
// and only another finish stalls until the receiver has taken it.
// Reset is synchronous; it empties both sequences and clears the output valid flag.
// The row RAM needs no clearing pass: until the first sweep of a pair has
// written it, each row cell is taken as its index.
module token_edit_distance_core #(
  parameter int MAX_FIRST_LEN = 256,
  parameter int TOKEN_WIDTH   = 32,
  parameter int COST_WIDTH    = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ted_pkg::TOKEN_BITS-1:0] s_tdata,   // [31:0] token
  input  logic [ted_pkg::CMD_BITS-1:0]   s_tuser,   // [1:0] cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ted_pkg::DIST_BITS-1:0]  m_tdata,   // [15:0] distance
  output logic                           m_tuser    // [0] error
);

  import ted_pkg::*;

  localparam int TW = (TOKEN_WIDTH < TOKEN_BITS) ? TOKEN_WIDTH : TOKEN_BITS;
  localparam int CW = $clog2(MAX_FIRST_LEN + 1);
  localparam int AW = (MAX_FIRST_LEN > 1) ? $clog2(MAX_FIRST_LEN) : 1;
  localparam int XW = CW + COST_WIDTH;
  localparam int DW = COST_WIDTH + DIST_BITS;

  localparam logic [COST_WIDTH-1:0] COST_MAX = '1;
  localparam logic [CW-1:0]         MAX_CNT  = CW'(MAX_FIRST_LEN);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_STEP = 1'b1;

  function automatic logic [COST_WIDTH-1:0] sat_inc(input logic [COST_WIDTH-1:0] v);
    return (v == COST_MAX) ? v : v + COST_WIDTH'(1);
  endfunction

  // Reset value of a row cell: its index, saturated
  function automatic logic [COST_WIDTH-1:0] sat_count(input logic [CW-1:0] v);
    logic [XW-1:0] wide;
    wide = XW'(v);
    return (wide > XW'(COST_MAX)) ? COST_MAX : wide[COST_WIDTH-1:0];
  endfunction

  logic                  state;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         first_count;
  logic                  stepped;
  logic                  overflow;
  logic [COST_WIDTH-1:0] corner;
  logic [COST_WIDTH-1:0] diag;
  logic [COST_WIDTH-1:0] left;
  logic [COST_WIDTH-1:0] last_cost;
  logic [TW-1:0]         tok_q;

  logic                  in_acc;
  logic                  is_load;
  logic                  is_step;
  logic                  is_finish;
  logic                  out_free;
  logic [CW-1:0]         cnt_m1;
  logic [AW-1:0]         rd_addr;
  logic                  tok_we;
  logic [TW-1:0]         tok_rdata;
  logic [COST_WIDTH-1:0] row_rdata;
  logic [COST_WIDTH-1:0] above;
  logic [COST_WIDTH-1:0] min_lt;
  logic [COST_WIDTH-1:0] min3;
  logic [COST_WIDTH-1:0] cell_cost;
  logic [COST_WIDTH-1:0] final_cost;
  logic [DW-1:0]         final_wide;
  logic [DIST_BITS-1:0]  dist_sat;

  assign is_load   = (s_tuser == CMD_LOAD);
  assign is_step   = (s_tuser == CMD_STEP);
  assign is_finish = (s_tuser == CMD_FINISH);
  assign out_free  = !m_tvalid || m_tready;

  // Take nothing during a sweep; hold off a finish while the previous result is still waiting
  assign s_tready = (state == S_IDLE) && (!is_finish || out_free);
  assign in_acc   = s_tvalid && s_tready;

  assign tok_we  = in_acc && is_load && !stepped && (first_count < MAX_CNT);
  assign cnt_m1  = cnt - CW'(1);
  assign rd_addr = (state == S_STEP) ? cnt[AW-1:0] : '0;

  ted_ram #(
    .WIDTH (TW),
    .DEPTH (MAX_FIRST_LEN)
  ) u_tok_ram (
    .clk   (clk),
    .we    (tok_we),
    .waddr (first_count[AW-1:0]),
    .wdata (s_tdata[TW-1:0]),
    .raddr (rd_addr),
    .rdata (tok_rdata)
  );

  ted_ram #(
    .WIDTH (COST_WIDTH),
    .DEPTH (MAX_FIRST_LEN)
  ) u_row_ram (
    .clk   (clk),
    .we    (state == S_STEP),
    .waddr (cnt_m1[AW-1:0]),
    .wdata (cell_cost),
    .raddr (rd_addr),
    .rdata (row_rdata)
  );

  // Cell update: match takes the diagonal, otherwise one more than the cheapest neighbour
  always_comb begin
    above     = stepped ? row_rdata : sat_count(cnt);
    min_lt    = (left < above) ? left : above;
    min3      = (min_lt < diag) ? min_lt : diag;
    cell_cost = (tok_rdata == tok_q) ? diag : sat_inc(min3);
  end

  always_comb begin
    if (first_count == '0) begin
      final_cost = corner;
    end else if (stepped) begin
      final_cost = last_cost;
    end else begin
      final_cost = sat_count(first_count);
    end
    final_wide = DW'(final_cost);
    dist_sat = (final_wide > DW'(DIST_MAX)) ? DIST_MAX : final_wide[DIST_BITS-1:0];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      first_count <= '0;
      stepped     <= 1'b0;
      overflow    <= 1'b0;
      corner      <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (in_acc && is_finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && is_load && !stepped) begin
            if (first_count < MAX_CNT) begin
              first_count <= first_count + CW'(1);
            end else begin
              overflow <= 1'b1;
            end
          end
          if (in_acc && is_step) begin
            corner  <= sat_inc(corner);
            cnt     <= CW'(1);
            // with tokens loaded, the row counts as written once the sweep ends
            if (first_count != '0) begin
              state <= S_STEP;
            end else begin
              stepped <= 1'b1;
            end
          end
          if (in_acc && is_finish) begin
            first_count <= '0;
            stepped     <= 1'b0;
            overflow    <= 1'b0;
            corner      <= '0;
          end
        end
        S_STEP: begin
          if (cnt == first_count) begin
            state   <= S_IDLE;
            stepped <= 1'b1;
          end else begin
            cnt <= cnt + CW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      if (in_acc && is_step) begin
        tok_q <= s_tdata[TW-1:0];
        diag  <= corner;
        left  <= sat_inc(corner);
      end
      if (in_acc && is_finish) begin
        m_tdata <= dist_sat;
        m_tuser <= overflow;
      end
    end else begin
      diag <= above;
      left <= cell_cost;
      if (cnt == first_count) begin
        last_cost <= cell_cost;
      end
    end
  end

endmodule

>>> design/ted_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module ted_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
